// File: hw/rtl/hpts_pkg.sv
// Package for the haptic pulse train scheduler.
// Holds the item structs, operation codes and shared control flag type.
`timescale 1ns / 1ps

package hpts_pkg;

  localparam int DurationBitsDefault = 16;
  localparam int FieldBits           = 16;
  localparam int CountBits           = 8;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_START_COUNT  = 2'd1,
    OP_START_REPEAT = 2'd2,
    OP_STOP         = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  operation;
    logic [CountBits-1:0] pulse_count;
    logic [FieldBits-1:0] on_time;
    logic [FieldBits-1:0] off_time;
    logic [FieldBits-1:0] elapsed;
  } cmd_item_t;

  typedef struct packed {
    logic                 motor_drive;
    logic                 busy_res;
    logic [CountBits-1:0] pulses_remaining;
  } res_item_t;

  typedef struct packed {
    logic train_active;
    logic repeat_mode;
    logic in_gap;
    logic motor_level;
  } ctrl_t;

endpackage

// File: hw/rtl/hpts_step.sv
// Next-state logic of the pulse train scheduler for one command item.
// Depends on hpts_pkg for the item struct, operation codes and flags.
`timescale 1ns / 1ps

module hpts_step import hpts_pkg::*; #(
  parameter int DURATION_BITS = DurationBitsDefault
) (
  input  cmd_item_t                 item,
  input  ctrl_t                     ctrl,
  input  logic [DURATION_BITS-1:0]  phase_left,
  input  logic [CountBits-1:0]      pulse_left,
  input  logic [DURATION_BITS-1:0]  on_duration,
  input  logic [DURATION_BITS-1:0]  off_duration,
  output ctrl_t                     ctrl_next,
  output logic [DURATION_BITS-1:0]  phase_left_next,
  output logic [CountBits-1:0]      pulse_left_next,
  output logic [DURATION_BITS-1:0]  on_duration_next,
  output logic [DURATION_BITS-1:0]  off_duration_next
);

  logic [DURATION_BITS-1:0] on_t;
  logic [DURATION_BITS-1:0] off_t;
  logic [DURATION_BITS-1:0] dt;

  generate
    if (DURATION_BITS > FieldBits) begin : g_widen
      assign on_t  = {{(DURATION_BITS-FieldBits){1'b0}}, item.on_time};
      assign off_t = {{(DURATION_BITS-FieldBits){1'b0}}, item.off_time};
      assign dt    = {{(DURATION_BITS-FieldBits){1'b0}}, item.elapsed};
    end else if (DURATION_BITS == FieldBits) begin : g_same
      assign on_t  = item.on_time;
      assign off_t = item.off_time;
      assign dt    = item.elapsed;
    end else begin : g_narrow
      assign on_t  = item.on_time[DURATION_BITS-1:0];
      assign off_t = item.off_time[DURATION_BITS-1:0];
      assign dt    = item.elapsed[DURATION_BITS-1:0];
    end
  endgenerate

  always_comb begin
    ctrl_next         = ctrl;
    phase_left_next   = phase_left;
    pulse_left_next   = pulse_left;
    on_duration_next  = on_duration;
    off_duration_next = off_duration;
    unique case (item.operation)
      OP_TICK: begin
        if (ctrl.train_active && (dt != '0)) begin
          if (dt < phase_left) begin
            phase_left_next = phase_left - dt;
          end else if (!ctrl.in_gap) begin
            ctrl_next.motor_level = 1'b0;
            if (ctrl.repeat_mode || (pulse_left > 8'd1)) begin
              if (!ctrl.repeat_mode) begin
                pulse_left_next = pulse_left - 8'd1;
              end
              ctrl_next.in_gap = 1'b1;
              phase_left_next  = off_duration;
            end else begin
              ctrl_next.train_active = 1'b0;
              ctrl_next.in_gap       = 1'b0;
              phase_left_next        = '0;
            end
          end else begin
            ctrl_next.in_gap      = 1'b0;
            ctrl_next.motor_level = 1'b1;
            phase_left_next       = on_duration;
          end
        end
      end
      OP_START_COUNT, OP_START_REPEAT: begin
        ctrl_next.train_active = 1'b1;
        ctrl_next.repeat_mode  = (item.operation == OP_START_REPEAT);
        ctrl_next.in_gap       = 1'b0;
        ctrl_next.motor_level  = 1'b1;
        pulse_left_next        = (item.operation == OP_START_REPEAT) ? '0 : item.pulse_count;
        on_duration_next       = on_t;
        off_duration_next      = off_t;
        phase_left_next        = on_t;
      end
      OP_STOP: begin
        ctrl_next.train_active = 1'b0;
        ctrl_next.repeat_mode  = 1'b0;
        ctrl_next.in_gap       = 1'b0;
        ctrl_next.motor_level  = 1'b0;
      end
      default: begin
        ctrl_next = ctrl;
      end
    endcase
  end

endmodule

// File: hw/rtl/haptic_pulse_train_scheduler_core.sv
// Top level of the haptic pulse train scheduler: command and result channels.
// Depends on hpts_pkg and hpts_step.
`timescale 1ns / 1ps

// Each command item (tick, start counted train, start repeating train, stop)
// yields exactly one result item showing motor level, busy flag and pulses
// left after that command. An item is held in the command register and then
// moves to the result register while the train state updates, so one item
// is taken every cycle while the result side keeps up; a stalled result
// holds the command register and then stalls the command side. Durations
// are kept modulo 2^DURATION_BITS.
module haptic_pulse_train_scheduler_core import hpts_pkg::*; #(
  parameter int DURATION_BITS = DurationBitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  logic                     cmd_full;
  cmd_item_t                cmd_reg;
  logic                     advance;
  ctrl_t                    ctrl;
  ctrl_t                    ctrl_next;
  logic [DURATION_BITS-1:0] phase_left;
  logic [DURATION_BITS-1:0] phase_left_next;
  logic [CountBits-1:0]     pulse_left;
  logic [CountBits-1:0]     pulse_left_next;
  logic [DURATION_BITS-1:0] on_duration;
  logic [DURATION_BITS-1:0] on_duration_next;
  logic [DURATION_BITS-1:0] off_duration;
  logic [DURATION_BITS-1:0] off_duration_next;

  assign advance   = cmd_full && (!res_valid || !res_stall);
  assign cmd_stall = cmd_full && !advance;

  hpts_step #(
    .DURATION_BITS(DURATION_BITS)
  ) u_step (
    .item              (cmd_reg),
    .ctrl              (ctrl),
    .phase_left        (phase_left),
    .pulse_left        (pulse_left),
    .on_duration       (on_duration),
    .off_duration      (off_duration),
    .ctrl_next         (ctrl_next),
    .phase_left_next   (phase_left_next),
    .pulse_left_next   (pulse_left_next),
    .on_duration_next  (on_duration_next),
    .off_duration_next (off_duration_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full     <= 1'b0;
      res_valid    <= 1'b0;
      ctrl         <= '0;
      phase_left   <= '0;
      pulse_left   <= '0;
      on_duration  <= '0;
      off_duration <= '0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        cmd_full <= 1'b1;
        cmd_reg  <= cmd;
      end else if (advance) begin
        cmd_full <= 1'b0;
      end
      if (advance) begin
        ctrl                 <= ctrl_next;
        phase_left           <= phase_left_next;
        pulse_left           <= pulse_left_next;
        on_duration          <= on_duration_next;
        off_duration         <= off_duration_next;
        res_valid            <= 1'b1;
        res.motor_drive      <= ctrl_next.motor_level;
        res.busy_res         <= ctrl_next.train_active;
        res.pulses_remaining <= pulse_left_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_motor_needs_train: assert property (@(posedge clk) disable iff (rst)
    ctrl.motor_level |-> ctrl.train_active)
    else $error("motor on without an active train");

  a_gap_motor_off: assert property (@(posedge clk) disable iff (rst)
    ctrl.in_gap |-> !ctrl.motor_level)
    else $error("motor on during a gap");

  a_repeat_no_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.repeat_mode |-> (pulse_left == '0))
    else $error("repeating train with a pulse count");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res_valid && (res.busy_res == ctrl.train_active)))
    else $error("advanced item left no matching result");

endmodule

// File: test/hpts_checker.sv
// Checker for the haptic pulse train scheduler: watches command and result channels,
// tracks train state for each accepted command item and compares every result item.
// Depends on hpts_pkg.
`timescale 1ns / 1ps

module hpts_checker import hpts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_stall,
  input  cmd_item_t cmd,
  input  logic      res_valid,
  input  logic      res_stall,
  input  res_item_t res,
  output int        fail_count,
  output int        pending_count,
  output int        checked_count
);

  localparam int DurBits = 16;

  logic               train_on;
  logic               repeating;
  logic               gap_phase;
  logic               drive_level;
  logic [17:0]        time_left;
  logic [7:0]         count_left;
  logic [DurBits-1:0] on_ms;
  logic [DurBits-1:0] off_ms;
  res_item_t          motor_status_q[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 30) begin
      $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic advance_train(input cmd_item_t c);
    logic [DurBits-1:0] dt;
    res_item_t          status;
    dt = c.elapsed[DurBits-1:0];
    case (c.operation)
      OP_TICK: begin
        if (train_on && dt != '0) begin
          if (18'(dt) < time_left) begin
            time_left = time_left - 18'(dt);
          end else if (!gap_phase) begin
            drive_level = 1'b0;
            if (repeating || count_left > 8'd1) begin
              if (!repeating) begin
                count_left = count_left - 8'd1;
              end
              gap_phase = 1'b1;
              time_left = 18'(off_ms);
            end else begin
              train_on  = 1'b0;
              gap_phase = 1'b0;
              time_left = '0;
            end
          end else begin
            gap_phase   = 1'b0;
            time_left   = 18'(on_ms);
            drive_level = 1'b1;
          end
        end
      end
      OP_START_COUNT, OP_START_REPEAT: begin
        train_on    = 1'b1;
        repeating   = (c.operation == OP_START_REPEAT);
        count_left  = repeating ? 8'd0 : c.pulse_count;
        on_ms       = c.on_time[DurBits-1:0];
        off_ms      = c.off_time[DurBits-1:0];
        gap_phase   = 1'b0;
        time_left   = 18'(on_ms);
        drive_level = 1'b1;
      end
      default: begin
        train_on    = 1'b0;
        repeating   = 1'b0;
        gap_phase   = 1'b0;
        drive_level = 1'b0;
      end
    endcase
    status.motor_drive      = drive_level;
    status.busy_res         = train_on;
    status.pulses_remaining = count_left;
    motor_status_q.push_back(status);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      train_on      = 1'b0;
      repeating     = 1'b0;
      gap_phase     = 1'b0;
      drive_level   = 1'b0;
      time_left     = '0;
      count_left    = '0;
      on_ms         = '0;
      off_ms        = '0;
      fail_count    = 0;
      checked_count = 0;
      motor_status_q.delete();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        advance_train(cmd);
      end
      if (res_valid && !res_stall) begin
        if (motor_status_q.size() == 0) begin
          report_mismatch("unexpected result item", int'(res), 0);
        end else begin
          if (res.motor_drive !== motor_status_q[0].motor_drive) begin
            report_mismatch("motor_drive", res.motor_drive, motor_status_q[0].motor_drive);
          end
          if (res.busy_res !== motor_status_q[0].busy_res) begin
            report_mismatch("busy_res", res.busy_res, motor_status_q[0].busy_res);
          end
          if (res.pulses_remaining !== motor_status_q[0].pulses_remaining) begin
            report_mismatch("pulses_remaining", res.pulses_remaining,
                            motor_status_q[0].pulses_remaining);
          end
          void'(motor_status_q.pop_front());
          checked_count++;
        end
      end
    end
    pending_count = motor_status_q.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top for haptic_pulse_train_scheduler_core: clock, reset, command
// stimulus and result-side stalls; hpts_checker does prediction and comparison.
// Depends on hpts_pkg, hpts_checker and the core.
`timescale 1ns / 1ps

module tb_top;
  import hpts_pkg::*;

  localparam int RandomItems = 650;
  localparam int HoldCycles  = 48;
  localparam int CycleLimit  = 200000;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd_item;
  logic      res_valid;
  logic      res_stall;
  res_item_t res_item;

  int fail_count;
  int pending_count;
  int checked_count;
  int cycle_count;
  int items_sent;
  int directed_items;
  bit idle_on;
  bit long_hold;
  bit hold_done;
  bit drain_done;

  haptic_pulse_train_scheduler_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_item)
  );

  hpts_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd_item),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res_item),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_item  = '0;
    res_stall = 1'b0;
    idle_on   = 1'b1;
    long_hold = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("haptic_pulse_train_scheduler_core regression: fail");
      $finish;
    end
  end

  always begin
    @(posedge clk);
    if (long_hold) begin
      res_stall <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      res_stall <= 1'b0;
      long_hold = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_stall <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      res_stall <= 1'b0;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic send_item(input cmd_item_t c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drive_cmd(input op_t op, input logic [7:0] count, input logic [15:0] on_ms,
                           input logic [15:0] off_ms, input logic [15:0] dt);
    cmd_item_t c;
    c.operation   = op;
    c.pulse_count = count;
    c.on_time     = on_ms;
    c.off_time    = off_ms;
    c.elapsed     = dt;
    if (!(op == OP_TICK && dt == 16'd0)) begin
      items_sent++;
    end
    send_item(c);
  endtask

  task automatic run_train_sequence();
    int          ticks;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] dt;
    logic [7:0]  count;
    on_ms  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    off_ms = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    count  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    if ($urandom_range(0, 9) < 7) begin
      drive_cmd(OP_START_COUNT, count, on_ms, off_ms, 16'($urandom));
    end else begin
      drive_cmd(OP_START_REPEAT, 8'($urandom), on_ms, off_ms, 16'($urandom));
    end
    ticks = $urandom_range(2, 25);
    repeat (ticks) begin
      if ($urandom_range(0, 14) == 0) begin
        drive_cmd(OP_STOP, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        dt = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25));
        drive_cmd(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), dt);
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    items_sent  = 0;
    hold_done   = 1'b0;
    drain_done  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, then a three-pulse train walked through every phase
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd5);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd0);
    drive_cmd(OP_START_COUNT,  8'd3,   16'd10,    16'd20,    16'd0);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd0);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd4);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd6);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'hFFFF);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd10);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd20);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd11);
    // zero count with zero durations
    drive_cmd(OP_START_COUNT,  8'd0,   16'd0,     16'd0,     16'd0);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd1);
    // largest count and durations, then stop mid-train
    drive_cmd(OP_START_COUNT,  8'hFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
    drive_cmd(OP_TICK,         8'hFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'hFFFE);
    drive_cmd(OP_STOP,         8'd0,   16'd0,     16'd0,     16'd0);
    // repeating train, replaced by a counted one while running
    drive_cmd(OP_START_REPEAT, 8'hFF,  16'd1,     16'd0,     16'hFFFF);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd1);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd1);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd1);
    drive_cmd(OP_START_COUNT,  8'd2,   16'd3,     16'd3,     16'd0);
    drive_cmd(OP_STOP,         8'hFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
    drive_cmd(OP_TICK,         8'd0,   16'd0,     16'd0,     16'd7);
    directed_items = items_sent;

    while (items_sent < directed_items + RandomItems) begin
      if (items_sent > directed_items + 150 && !hold_done) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent > directed_items + 350 && !drain_done) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        drain_done = 1'b1;
      end
      idle_on = !((items_sent > directed_items + 250 && items_sent < directed_items + 320) ||
                  items_sent > directed_items + RandomItems - 100);
      if ($urandom_range(0, 9) == 0) begin
        drive_cmd(op_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end else begin
        run_train_sequence();
      end
    end

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d command items (%0d directed), %0d result items checked",
             items_sent, directed_items, checked_count);
    $display("counted, repeating, stop and replace cases, a %0d-cycle result hold and a drain",
             HoldCycles);
    if (fail_count == 0 && pending_count == 0) begin
      $display("haptic_pulse_train_scheduler_core regression: pass");
    end else begin
      $display("haptic_pulse_train_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule
